@@ rtl/dual_delimiter_stuffing_decoder_assert.svh @@
// Assertion macros for the dual delimiter stuffing decoder.
`ifndef DUAL_DELIMITER_STUFFING_DECODER_ASSERT_SVH
`define DUAL_DELIMITER_STUFFING_DECODER_ASSERT_SVH

// The condition must hold at every clock edge outside reset.
`define DDSD_ASSERT_NOW(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("ddsd assertion failed");

// When the trigger holds, the consequence must hold in the next cycle.
`define DDSD_ASSERT_NEXT(label, clk, rst_n, trig, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error("ddsd assertion failed");

`endif

@@ rtl/ddsd_pkg.sv @@
// Shared types and constants for the dual delimiter stuffing decoder.
package ddsd_pkg;

    localparam int unsigned MAX_FRAME_LEN_DEF = 255;
    localparam int unsigned BYTE_W            = 8;
    localparam int unsigned POS_W             = 9;
    localparam int unsigned PTR_W             = 10;
    localparam int unsigned CFG_IDX_W         = 2;
    localparam int unsigned CFG_DATA_W        = 8;
    localparam logic [POS_W-1:0] POS_MAX      = 9'd511;
    localparam logic [PTR_W-1:0] OVERHEAD_LEN = 10'd4;

    localparam logic [CFG_IDX_W-1:0] REG_SOF = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EOF = 2'd1;

    localparam logic [BYTE_W-1:0] SOF_RESET = 8'd0;
    localparam logic [BYTE_W-1:0] EOF_RESET = 8'd255;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_TOO_LONG  = 3'd1,
        ST_TOO_SHORT = 3'd2,
        ST_BAD_START = 3'd3,
        ST_BAD_END   = 3'd4,
        ST_CHAIN     = 3'd5
    } status_t;

    typedef struct packed {
        logic [BYTE_W-1:0] sof_char;
        logic [BYTE_W-1:0] eof_char;
    } cfg_t;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] dec_byte;
        logic              is_status;
        status_t           status;
        logic [BYTE_W-1:0] payload_len;
    } result_t;

endpackage

@@ rtl/dual_delimiter_stuffing_decoder.sv @@
// Top level of the dual delimiter stuffing decoder.
//
// Input channel: in_valid / in_stall carry one encoded frame byte (enc_byte)
// and frame_end, which marks the last byte of a frame. A transaction takes
// place at a clock edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall carry one result. Payload bytes come
// out as data results (is_status low); the last byte of a frame gives one
// status result with status and payload_len. Header bytes give no result.
// Configuration: cfg_valid / cfg_ready write sof_char (index 0) or eof_char
// (index 1); cfg_ready is always high. Write only while the block is idle.
// An input transaction loads the input register, and its decode loads the result
// register, which drives out_valid, once the result register is free.
// One byte is accepted per cycle while the receiver does not stall; the
// position and chain pointers update on each decoded byte.
// Reset clears the frame state, sets sof_char to 0 and eof_char to 255.
// When the receiver stalls, the result register holds and in_stall rises
// as soon as the input register is full.
`include "dual_delimiter_stuffing_decoder_assert.svh"

module dual_delimiter_stuffing_decoder
#(
    parameter int unsigned MAX_FRAME_LEN = ddsd_pkg::MAX_FRAME_LEN_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [ddsd_pkg::BYTE_W-1:0]       enc_byte,
    input  logic                              frame_end,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [ddsd_pkg::BYTE_W-1:0]       dec_byte,
    output logic                              is_status,
    output logic [2:0]                        status,
    output logic [ddsd_pkg::BYTE_W-1:0]       payload_len,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ddsd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ddsd_pkg::CFG_DATA_W-1:0]   cfg_data
);

    ddsd_pkg::cfg_t    cfg;
    ddsd_pkg::result_t res;

    logic                        s1_valid_reg, s1_valid_next;
    logic [ddsd_pkg::BYTE_W-1:0] s1_byte_reg;
    logic                        s1_last_reg;
    logic                        out_valid_reg;
    logic [ddsd_pkg::BYTE_W-1:0] dec_byte_reg;
    logic                        is_status_reg;
    ddsd_pkg::status_t           status_reg;
    logic [ddsd_pkg::BYTE_W-1:0] payload_len_reg;

    logic in_accept;
    logic s2_free;
    logic fire;

    assign s2_free   = !out_valid_reg || !out_stall;
    assign fire      = s1_valid_reg && s2_free;
    assign in_stall  = s1_valid_reg && !s2_free;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        if (in_accept)
            s1_valid_next = 1'b1;
        else if (fire)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    ddsd_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ddsd_frame_dec #(
        .MAX_FRAME_LEN (MAX_FRAME_LEN)
    ) u_dec
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .enc_byte  (s1_byte_reg),
        .frame_end (s1_last_reg),
        .cfg       (cfg),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_byte_reg <= enc_byte;
            s1_last_reg <= frame_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (fire)
            out_valid_reg <= res.valid;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            dec_byte_reg    <= res.dec_byte;
            is_status_reg   <= res.is_status;
            status_reg      <= res.status;
            payload_len_reg <= res.payload_len;
        end
    end

    assign out_valid   = out_valid_reg;
    assign dec_byte    = dec_byte_reg;
    assign is_status   = is_status_reg;
    assign status      = status_reg;
    assign payload_len = payload_len_reg;

    `DDSD_ASSERT_NEXT(a_accept_fills_s1, clk, rst_n, in_accept, s1_valid_reg)
    `DDSD_ASSERT_NOW(a_stall_only_when_full, clk, rst_n, !in_stall || s1_valid_reg)
    `DDSD_ASSERT_NOW(a_len_only_on_ok, clk, rst_n,
        !out_valid_reg || payload_len_reg == '0 || (is_status_reg && status_reg == ddsd_pkg::ST_OK))
    `DDSD_ASSERT_NOW(a_data_has_no_status, clk, rst_n,
        !out_valid_reg || is_status_reg || status_reg == ddsd_pkg::ST_OK)

endmodule

@@ rtl/ddsd_cfg_regs.sv @@
// Configuration registers holding the two reserved delimiter values.
module ddsd_cfg_regs
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ddsd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ddsd_pkg::CFG_DATA_W-1:0]    cfg_data,
    output ddsd_pkg::cfg_t                     cfg
);

    logic [ddsd_pkg::BYTE_W-1:0] sof_reg;
    logic [ddsd_pkg::BYTE_W-1:0] eof_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sof_reg <= ddsd_pkg::SOF_RESET;
            eof_reg <= ddsd_pkg::EOF_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                ddsd_pkg::REG_SOF: sof_reg <= cfg_data;
                ddsd_pkg::REG_EOF: eof_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg.sof_char = sof_reg;
    assign cfg.eof_char = eof_reg;

endmodule

@@ rtl/ddsd_frame_dec.sv @@
// Frame position and chain pointer tracking with per-byte decode.
module ddsd_frame_dec
#(
    parameter int unsigned MAX_FRAME_LEN = ddsd_pkg::MAX_FRAME_LEN_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          fire,
    input  logic [ddsd_pkg::BYTE_W-1:0]   enc_byte,
    input  logic                          frame_end,
    input  ddsd_pkg::cfg_t                cfg,
    output ddsd_pkg::result_t             res
);

    localparam logic [ddsd_pkg::PTR_W-1:0] MAX_LEN = MAX_FRAME_LEN[ddsd_pkg::PTR_W-1:0];

    logic [ddsd_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [ddsd_pkg::PTR_W-1:0] start_ptr_reg, start_ptr_next;
    logic [ddsd_pkg::PTR_W-1:0] end_ptr_reg, end_ptr_next;
    logic                       first_bad_reg, first_bad_next;

    logic [ddsd_pkg::PTR_W-1:0] pos_ext;
    logic [ddsd_pkg::PTR_W-1:0] size;
    logic [ddsd_pkg::PTR_W-1:0] byte_ext;
    logic [ddsd_pkg::PTR_W-1:0] len_full;
    logic                       hit_start;
    logic                       hit_end;
    ddsd_pkg::status_t          st;

    assign pos_ext   = {1'b0, pos_reg};
    assign size      = pos_ext + 10'd1;
    assign byte_ext  = {2'b00, enc_byte};
    assign len_full  = size - ddsd_pkg::OVERHEAD_LEN;
    assign hit_start = (start_ptr_reg == pos_ext);
    assign hit_end   = (end_ptr_reg == pos_ext);

    always_comb
    begin
        if (size > MAX_LEN)
            st = ddsd_pkg::ST_TOO_LONG;
        else if (size < ddsd_pkg::OVERHEAD_LEN)
            st = ddsd_pkg::ST_TOO_SHORT;
        else if (first_bad_reg)
            st = ddsd_pkg::ST_BAD_START;
        else if (enc_byte != cfg.eof_char)
            st = ddsd_pkg::ST_BAD_END;
        else if (!hit_start || !hit_end)
            st = ddsd_pkg::ST_CHAIN;
        else
            st = ddsd_pkg::ST_OK;
    end

    always_comb
    begin
        pos_next       = pos_reg;
        start_ptr_next = start_ptr_reg;
        end_ptr_next   = end_ptr_reg;
        first_bad_next = first_bad_reg;
        res            = '0;

        if (frame_end)
        begin
            pos_next        = '0;
            start_ptr_next  = '0;
            end_ptr_next    = '0;
            first_bad_next  = 1'b0;
            res.valid       = 1'b1;
            res.is_status   = 1'b1;
            res.status      = st;
            res.payload_len = (st == ddsd_pkg::ST_OK) ? len_full[ddsd_pkg::BYTE_W-1:0] : '0;
        end
        else
        begin
            if (pos_reg < ddsd_pkg::POS_MAX)
                pos_next = pos_reg + 9'd1;
            case (pos_reg)
                9'd0: first_bad_next = (enc_byte != cfg.sof_char);
                9'd1: start_ptr_next = byte_ext + 10'd1;
                9'd2: end_ptr_next = byte_ext + 10'd2;
                default:
                begin
                    // The end delimiter wins when both chains land on this byte.
                    res.valid    = 1'b1;
                    res.dec_byte = enc_byte;
                    if (hit_start)
                    begin
                        start_ptr_next = start_ptr_reg + byte_ext;
                        res.dec_byte   = cfg.sof_char;
                    end
                    if (hit_end)
                    begin
                        end_ptr_next = end_ptr_reg + byte_ext;
                        res.dec_byte = cfg.eof_char;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            start_ptr_reg <= '0;
            end_ptr_reg   <= '0;
            first_bad_reg <= 1'b0;
        end
        else if (fire)
        begin
            pos_reg       <= pos_next;
            start_ptr_reg <= start_ptr_next;
            end_ptr_reg   <= end_ptr_next;
            first_bad_reg <= first_bad_next;
        end
    end

endmodule
